FILE: rtl/kctt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kctt_pkg;

  // Default sizes of the timer table.
  localparam int TIMER_SLOTS_DEF = 16;
  localparam int KEY_BITS_DEF    = 16;

  // Reset value of the time scale register (Q8.8, 1.0).
  localparam logic [15:0] TIME_SCALE_RESET = 16'd256;

  // Request operation codes.
  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_SET     = 2'd0;
  localparam logic [1:0] KIND_CANCEL  = 2'd1;
  localparam logic [1:0] KIND_QUERY   = 2'd2;
  localparam logic [1:0] KIND_EXPIRED = 2'd3;

  // Status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_MISSING = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;

  // One request.
  typedef struct packed {
    logic [1:0]         operation;
    logic [15:0]        timer_key;
    logic signed [31:0] time_value;
    logic [30:0]        elapsed;
  } req_t;

  // One result.
  typedef struct packed {
    logic [1:0]         result_kind;
    logic [1:0]         status;
    logic [15:0]        result_key;
    logic signed [31:0] remaining;
    logic               last;
  } rsp_t;

  // What the shared entry unit reports about the entry under the cursor.
  typedef struct packed {
    logic               hit;
    logic               expired;
    logic signed [31:0] dec;
  } alu_res_t;

endpackage

`default_nettype wire

FILE: rtl/kctt_store.sv
`timescale 1ns / 1ps
`default_nettype none

module kctt_store #(
  parameter int SLOTS    = kctt_pkg::TIMER_SLOTS_DEF,
  parameter int KEY_BITS = kctt_pkg::KEY_BITS_DEF,
  localparam int IW      = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [IW-1:0]       waddr,
  input  wire logic [KEY_BITS-1:0] wkey,
  input  wire logic signed [31:0]  wrem,
  input  wire logic [IW-1:0]       raddr,
  output logic [KEY_BITS-1:0]      rkey,
  output logic signed [31:0]       rrem
);

  logic [KEY_BITS-1:0] key_mem [SLOTS];
  logic signed [31:0]  rem_mem [SLOTS];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      rem_mem[waddr] <= wrem;
    end
    rkey <= key_mem[raddr];
    rrem <= rem_mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/kctt_scale.sv
`timescale 1ns / 1ps
`default_nettype none

module kctt_scale (
  input  wire logic [30:0] elapsed,
  input  wire logic [15:0] scale,
  output logic [30:0]      delta
);

  logic [46:0] prod;

  // Q15.16 times Q8.8, back to Q15.16, saturated at the largest positive time.
  assign prod  = 47'(elapsed) * 47'(scale);
  assign delta = (|prod[46:39]) ? 31'h7FFF_FFFF : prod[38:8];

endmodule

`default_nettype wire

FILE: rtl/kctt_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module kctt_alu #(
  parameter int KEY_BITS = kctt_pkg::KEY_BITS_DEF
) (
  input  wire logic [KEY_BITS-1:0] entry_key,
  input  wire logic [KEY_BITS-1:0] req_key,
  input  wire logic signed [31:0]  entry_rem,
  input  wire logic [30:0]         delta,
  output kctt_pkg::alu_res_t       res
);

  logic signed [32:0] diff;

  // Saturating decrement; only the low side can overflow.
  assign diff = {entry_rem[31], entry_rem} - {2'b00, delta};

  always_comb begin
    res.hit     = (entry_key == req_key);
    res.expired = entry_rem[31] || (entry_rem == 32'sd0);
    if (diff[32] != diff[31]) begin
      res.dec = 32'sh8000_0000;
    end else begin
      res.dec = diff[31:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/keyed_countdown_timer_table_core.sv
// Sequence: an accepted request runs a setup step, a walk over each live entry and a closing
// step while busy; the final result strobes in the cycle after the closing step.
// Requests do not overlap: start is taken only while idle. The table has a single read and
// write port and is walked one entry per cycle.
// Tick expiries strobe during the walk; the receiver cannot stall results.
// Reset (synchronous, rst high) empties the table and sets time_scale to 1.0.
`timescale 1ns / 1ps
`default_nettype none

module keyed_countdown_timer_table_core #(
  parameter int TIMER_SLOTS = kctt_pkg::TIMER_SLOTS_DEF,
  parameter int KEY_BITS    = kctt_pkg::KEY_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire kctt_pkg::req_t  request,
  input  wire logic            cfg_we,
  input  wire logic [15:0]     cfg_wdata,
  output logic                 result_valid,
  output kctt_pkg::rsp_t       result
);

  localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CW = $clog2(TIMER_SLOTS + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SETUP = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;

  logic [1:0]          state;
  kctt_pkg::req_t      req_q;
  logic [KEY_BITS-1:0] key_q;
  logic [15:0]         time_scale;
  logic [30:0]         delta;
  logic [30:0]         delta_calc;
  logic [CW-1:0]       cur;
  logic [CW-1:0]       cur_next;
  logic [CW-1:0]       wptr;
  logic [CW-1:0]       count;
  logic                found;
  logic signed [31:0]  found_rem;
  logic                pend_valid;
  logic [KEY_BITS-1:0] pend_key;
  logic                in_range;
  logic                has_room;
  logic                result_valid_next;
  kctt_pkg::rsp_t      result_next;

  logic                we;
  logic [IW-1:0]       waddr;
  logic [KEY_BITS-1:0] wkey;
  logic signed [31:0]  wrem;
  logic [IW-1:0]       raddr;
  logic [KEY_BITS-1:0] rd_key;
  logic signed [31:0]  rd_rem;
  kctt_pkg::alu_res_t  alu;

  assign busy     = (state != S_IDLE);
  assign cur_next = cur + CW'(1);
  assign in_range = (cur != count);
  assign has_room = (count != CW'(TIMER_SLOTS));

  // Table storage.
  kctt_store #(
    .SLOTS    (TIMER_SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wkey  (wkey),
    .wrem  (wrem),
    .raddr (raddr),
    .rkey  (rd_key),
    .rrem  (rd_rem)
  );

  // Tick scaling, registered in the setup cycle.
  kctt_scale u_scale (
    .elapsed (req_q.elapsed),
    .scale   (time_scale),
    .delta   (delta_calc)
  );

  // Shared compare and decrement unit for the entry under the cursor.
  kctt_alu #(
    .KEY_BITS (KEY_BITS)
  ) u_alu (
    .entry_key (rd_key),
    .req_key   (key_q),
    .entry_rem (rd_rem),
    .delta     (delta),
    .res       (alu)
  );

  // Read address runs one entry ahead of the cursor.
  always_comb begin
    if (state == S_WALK) begin
      raddr = cur_next[IW-1:0];
    end else begin
      raddr = '0;
    end
  end

  // Table write port: compaction for tick and cancel, update or append for set.
  always_comb begin
    we    = 1'b0;
    waddr = wptr[IW-1:0];
    wkey  = rd_key;
    wrem  = rd_rem;
    if (state == S_WALK) begin
      if (in_range) begin
        unique case (req_q.operation)
          kctt_pkg::OP_TICK: begin
            we   = !alu.expired;
            wrem = alu.dec;
          end
          kctt_pkg::OP_CANCEL: begin
            we = !(alu.hit && !found);
          end
          kctt_pkg::OP_SET: begin
            we    = alu.hit && !found;
            waddr = cur[IW-1:0];
            wrem  = req_q.time_value;
          end
          kctt_pkg::OP_QUERY: begin
            we = 1'b0;
          end
        endcase
      end else if (req_q.operation == kctt_pkg::OP_SET && !found && has_room) begin
        we    = 1'b1;
        waddr = count[IW-1:0];
        wkey  = key_q;
        wrem  = req_q.time_value;
      end
    end
  end

  // Result for the next cycle: expiries during the walk, the answer in the closing cycle.
  always_comb begin
    result_valid_next = 1'b0;
    result_next       = result;
    if (state == S_WALK) begin
      if (in_range) begin
        // Each expiry is held back until the next one is found so the final one can carry last.
        if (req_q.operation == kctt_pkg::OP_TICK && alu.expired && pend_valid) begin
          result_valid_next       = 1'b1;
          result_next.result_kind = kctt_pkg::KIND_EXPIRED;
          result_next.status      = kctt_pkg::STAT_OK;
          result_next.result_key  = 16'(pend_key);
          result_next.remaining   = 32'sd0;
          result_next.last        = 1'b0;
        end
      end else begin
        result_next.result_key = 16'(key_q);
        result_next.remaining  = 32'sd0;
        result_next.status     = kctt_pkg::STAT_OK;
        result_next.last       = 1'b1;
        unique case (req_q.operation)
          kctt_pkg::OP_TICK: begin
            result_valid_next       = pend_valid;
            result_next.result_kind = kctt_pkg::KIND_EXPIRED;
            result_next.result_key  = 16'(pend_key);
          end
          kctt_pkg::OP_CANCEL: begin
            result_valid_next       = 1'b1;
            result_next.result_kind = kctt_pkg::KIND_CANCEL;
            if (!found) begin
              result_next.status = kctt_pkg::STAT_MISSING;
            end
          end
          kctt_pkg::OP_QUERY: begin
            result_valid_next       = 1'b1;
            result_next.result_kind = kctt_pkg::KIND_QUERY;
            if (found) begin
              result_next.remaining = found_rem;
            end else begin
              result_next.status = kctt_pkg::STAT_MISSING;
            end
          end
          kctt_pkg::OP_SET: begin
            result_valid_next       = 1'b1;
            result_next.result_kind = kctt_pkg::KIND_SET;
            if (!found && !has_room) begin
              result_next.status = kctt_pkg::STAT_FULL;
            end
          end
        endcase
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    result <= result_next;
  end

  // Sequencer: setup, walk over the live entries, then answer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
      pend_valid   <= 1'b0;
      time_scale   <= kctt_pkg::TIME_SCALE_RESET;
    end else begin
      if (cfg_we) begin
        time_scale <= cfg_wdata;
      end
      result_valid <= result_valid_next;
      case (state)
        S_IDLE: begin
          if (start) begin
            req_q <= request;
            key_q <= KEY_BITS'(request.timer_key);
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          delta      <= delta_calc;
          cur        <= '0;
          wptr       <= '0;
          found      <= 1'b0;
          pend_valid <= 1'b0;
          state      <= S_WALK;
        end
        S_WALK: begin
          if (in_range) begin
            cur <= cur_next;
            unique case (req_q.operation)
              kctt_pkg::OP_TICK: begin
                if (alu.expired) begin
                  pend_valid <= 1'b1;
                  pend_key   <= rd_key;
                end else begin
                  wptr <= wptr + CW'(1);
                end
              end
              kctt_pkg::OP_CANCEL: begin
                if (alu.hit && !found) begin
                  found <= 1'b1;
                end else begin
                  wptr <= wptr + CW'(1);
                end
              end
              kctt_pkg::OP_QUERY: begin
                if (alu.hit && !found) begin
                  found     <= 1'b1;
                  found_rem <= rd_rem;
                end
              end
              kctt_pkg::OP_SET: begin
                if (alu.hit && !found) begin
                  found <= 1'b1;
                end
              end
            endcase
          end else begin
            state <= S_IDLE;
            unique case (req_q.operation)
              kctt_pkg::OP_TICK: begin
                count      <= wptr;
                pend_valid <= 1'b0;
              end
              kctt_pkg::OP_CANCEL: begin
                count <= wptr;
              end
              kctt_pkg::OP_QUERY: begin
              end
              kctt_pkg::OP_SET: begin
                if (!found && has_room) begin
                  count <= count + CW'(1);
                end
              end
            endcase
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/kctt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module kctt_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           result_valid,
  input wire kctt_pkg::rsp_t result
);

  // An accepted request keeps the block busy in the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // Results come only from work that was under way in the cycle before.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result without a request in progress");

  // The final result of a request coincides with the block going idle.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |-> !busy)
    else $error("final result while still busy");

  // Set, cancel and query answers are single results.
  a_single_answer: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.result_kind != kctt_pkg::KIND_EXPIRED |-> result.last)
    else $error("non-expiry result without last");

  // Expiry results always report ok and zero time.
  a_expiry_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.result_kind == kctt_pkg::KIND_EXPIRED
      |-> result.status == kctt_pkg::STAT_OK && result.remaining == 32'sd0)
    else $error("expiry result with bad fields");

endmodule

bind keyed_countdown_timer_table_core kctt_checker u_kctt_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);

`default_nettype wire
